@@ design/runs_above_below_test_macros.svh @@
// assertion macros for the runs above and below test block
`ifndef RUNS_ABOVE_BELOW_TEST_MACROS_SVH
`define RUNS_ABOVE_BELOW_TEST_MACROS_SVH

`ifndef SYNTHESIS

`define RABT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("runs test: same-cycle check failed");

`define RABT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("runs test: next-cycle check failed");

`else

`define RABT_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define RABT_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/rabt_pkg.sv @@
// shared constants for the runs above and below test block
`timescale 1ns / 1ps

package rabt_pkg;

    localparam int DEF_COUNT_WIDTH  = 20;
    localparam int DEF_SAMPLE_WIDTH = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    localparam int THRESH_W = 16;
    localparam int ZSQ_W    = 20;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd32735;
    localparam logic [ZSQ_W-1:0]    ZSQ_RESET    = 20'd38416;

    localparam int SCALE   = 10000;
    localparam int SCALE_W = $clog2(SCALE + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZSQ       = 2'd1;

endpackage

@@ design/runs_above_below_test.sv @@
// top level of the runs above and below threshold test
// Samples are taken one per clock while ready is high. Each is classed
// below or above the threshold register (a sample equal to it keeps the
// previous class and is counted in neither), and runs and both class counts
// are tallied with saturation. The sample marked last closes the sequence:
// the tallies are cleared for the next sequence and ready drops while the
// acceptance test runs on a single shift-add multiplier that retires one
// multiplier bit per cycle over seven products; a product ends early when
// its multiplier operand is small, and all products are skipped when any
// tally is zero. The result word is held in an output register, so new
// samples are taken while it waits; a closing sample that arrives while an
// earlier result word is still held keeps ready low for as long as that
// word waits.
`timescale 1ns / 1ps
`include "runs_above_below_test_macros.svh"

module runs_above_below_test #(
    parameter int COUNT_WIDTH  = rabt_pkg::DEF_COUNT_WIDTH,
    parameter int SAMPLE_WIDTH = rabt_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rabt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rabt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [SAMPLE_WIDTH-1:0]          sample,
    input  logic                             last,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [COUNT_WIDTH-1:0]           runs,
    output logic [COUNT_WIDTH-1:0]           below_count,
    output logic [COUNT_WIDTH-1:0]           above_count,
    output logic                             accepted
);

    import rabt_pkg::*;

    logic [SAMPLE_WIDTH-1:0] threshold_reg, threshold_next;
    logic [ZSQ_W-1:0]        zsq_reg, zsq_next;

    logic                   start;
    logic                   idle;
    logic [COUNT_WIDTH-1:0] runs_new;
    logic [COUNT_WIDTH-1:0] below_new;
    logic [COUNT_WIDTH-1:0] above_new;

    assign cfg_ready = 1'b1;
    assign in_ready  = idle;

    always_comb
    begin
        threshold_next = threshold_reg;
        zsq_next       = zsq_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_THRESHOLD: threshold_next = SAMPLE_WIDTH'(cfg_data[THRESH_W-1:0]);
                REG_ZSQ:       zsq_next       = cfg_data[ZSQ_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= SAMPLE_WIDTH'(THRESH_RESET);
            zsq_reg       <= ZSQ_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
            zsq_reg       <= zsq_next;
        end
    end

    rabt_count #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .last      (last),
        .threshold (threshold_reg),
        .start     (start),
        .runs_new  (runs_new),
        .below_new (below_new),
        .above_new (above_new)
    );

    rabt_test #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_test (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .runs_new    (runs_new),
        .below_new   (below_new),
        .above_new   (above_new),
        .zsq         (zsq_reg),
        .idle        (idle),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .runs        (runs),
        .below_count (below_count),
        .above_count (above_count),
        .accepted    (accepted)
    );

    // closing word starts the test and drops ready
    `RABT_ASSERT_NXT(a_last_busy, clk, rst_n, in_valid && in_ready && last, !in_ready)
    // an ordinary word never stalls the input
    `RABT_ASSERT_NXT(a_mid_ready, clk, rst_n, in_valid && in_ready && !last, in_ready)
    // a pass needs both classes present
    `RABT_ASSERT_IMP(a_pass_counts, clk, rst_n, out_valid && accepted, (below_count != '0) && (above_count != '0))

endmodule

@@ design/rabt_mul.sv @@
// shift-add multiplier shared by every product of the acceptance test
`timescale 1ns / 1ps

module rabt_mul #(
    parameter int P_W = 64,
    parameter int B_W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [P_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           done,
    output logic [P_W-1:0] prod
);

    logic           busy_reg, busy_next;
    logic [P_W-1:0] a_reg, a_next;
    logic [B_W-1:0] b_reg, b_next;
    logic [P_W-1:0] acc_reg, acc_next;

    assign done = busy_reg && (b_reg == '0);
    assign prod = acc_reg;

    always_comb
    begin
        busy_next = busy_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = a_reg << 1;
                b_next = b_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

endmodule

@@ design/rabt_count.sv @@
// sample classing, run detection and saturating tallies
`timescale 1ns / 1ps

module rabt_count #(
    parameter int COUNT_WIDTH  = 20,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic                    last,
    input  logic [SAMPLE_WIDTH-1:0] threshold,
    output logic                    start,
    output logic [COUNT_WIDTH-1:0]  runs_new,
    output logic [COUNT_WIDTH-1:0]  below_new,
    output logic [COUNT_WIDTH-1:0]  above_new
);

    logic                   prev_class_reg, prev_class_next;
    logic                   first_reg, first_next;
    logic [COUNT_WIDTH-1:0] runs_reg, runs_next;
    logic [COUNT_WIDTH-1:0] below_reg, below_next;
    logic [COUNT_WIDTH-1:0] above_reg, above_next;

    logic take;
    logic below_hit;
    logic above_hit;
    logic cls;

    assign take      = in_valid && in_ready;
    assign start     = take && last;
    assign below_hit = sample < threshold;
    assign above_hit = sample > threshold;

    always_comb
    begin
        cls = prev_class_reg;
        if (below_hit)
        begin
            cls = 1'b0;
        end
        else if (above_hit)
        begin
            cls = 1'b1;
        end

        below_new = below_reg;
        if (below_hit && (below_reg != '1))
        begin
            below_new = below_reg + COUNT_WIDTH'(1);
        end

        above_new = above_reg;
        if (above_hit && (above_reg != '1))
        begin
            above_new = above_reg + COUNT_WIDTH'(1);
        end

        runs_new = runs_reg;
        if ((first_reg || (cls != prev_class_reg)) && (runs_reg != '1))
        begin
            runs_new = runs_reg + COUNT_WIDTH'(1);
        end

        prev_class_next = prev_class_reg;
        first_next      = first_reg;
        runs_next       = runs_reg;
        below_next      = below_reg;
        above_next      = above_reg;
        if (take)
        begin
            if (last)
            begin
                prev_class_next = 1'b0;
                first_next      = 1'b1;
                runs_next       = '0;
                below_next      = '0;
                above_next      = '0;
            end
            else
            begin
                prev_class_next = cls;
                first_next      = 1'b0;
                runs_next       = runs_new;
                below_next      = below_new;
                above_next      = above_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_class_reg <= 1'b0;
            first_reg      <= 1'b1;
            runs_reg       <= '0;
            below_reg      <= '0;
            above_reg      <= '0;
        end
        else
        begin
            prev_class_reg <= prev_class_next;
            first_reg      <= first_next;
            runs_reg       <= runs_next;
            below_reg      <= below_next;
            above_reg      <= above_next;
        end
    end

endmodule

@@ design/rabt_test.sv @@
// sequencer for the acceptance test and the result word register
`timescale 1ns / 1ps

module rabt_test #(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [COUNT_WIDTH-1:0]      runs_new,
    input  logic [COUNT_WIDTH-1:0]      below_new,
    input  logic [COUNT_WIDTH-1:0]      above_new,
    input  logic [rabt_pkg::ZSQ_W-1:0]  zsq,
    output logic                        idle,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [COUNT_WIDTH-1:0]      runs,
    output logic [COUNT_WIDTH-1:0]      below_count,
    output logic [COUNT_WIDTH-1:0]      above_count,
    output logic                        accepted
);

    import rabt_pkg::*;

    localparam int N_W    = COUNT_WIDTH + 1;
    localparam int P2_W   = 2 * COUNT_WIDTH + 1;
    localparam int X_W    = 2 * COUNT_WIDTH + 2;
    localparam int M_W    = N_W + SCALE_W;
    localparam int T_W    = 2 * P2_W;
    localparam int LHS_W  = 2 * X_W + M_W;
    localparam int RT_W   = T_W + ZSQ_W;
    localparam int RHS_W  = RT_W + 2;
    localparam int P_W    = (LHS_W > RT_W) ? LHS_W : RT_W;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    localparam int BX_W   = (X_W > M_W) ? X_W : M_W;
    localparam int B_W    = (BX_W > ZSQ_W) ? BX_W : ZSQ_W;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_P2   = 9'b000000010,
        ST_LA   = 9'b000000100,
        ST_SQ   = 9'b000001000,
        ST_M    = 9'b000010000,
        ST_LHS  = 9'b000100000,
        ST_T    = 9'b001000000,
        ST_RHS  = 9'b010000000,
        ST_HOLD = 9'b100000000
    } test_state_t;

    test_state_t state_reg, state_next;
    logic        mul_start_reg, mul_start_next;
    logic        out_valid_reg, out_valid_next;
    logic        pass_reg, pass_next;

    logic [COUNT_WIDTH-1:0] r_reg, r_next;
    logic [COUNT_WIDTH-1:0] n1_reg, n1_next;
    logic [COUNT_WIDTH-1:0] n2_reg, n2_next;
    logic [N_W-1:0]         n_reg, n_next;
    logic [P2_W-1:0]        p2_reg, p2_next;
    logic [X_W-1:0]         x_reg, x_next;
    logic [M_W-1:0]         m_reg, m_next;
    logic [LHS_W-1:0]       lhs_reg, lhs_next;
    logic [T_W-1:0]         t_reg, t_next;

    logic [COUNT_WIDTH-1:0] runs_reg, runs_out_next;
    logic [COUNT_WIDTH-1:0] below_reg, below_out_next;
    logic [COUNT_WIDTH-1:0] above_reg, above_out_next;
    logic                   acc_flag_reg, acc_flag_next;

    logic [P_W-1:0]   mul_a;
    logic [B_W-1:0]   mul_b;
    logic             mul_done;
    logic [P_W-1:0]   mul_prod;
    logic [N_W-1:0]   r2m1;
    logic [X_W-1:0]   la;
    logic [X_W-1:0]   p2x2;
    logic [RHS_W-1:0] rhs;

    rabt_mul #(
        .P_W (P_W),
        .B_W (B_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign idle        = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign runs        = runs_reg;
    assign below_count = below_reg;
    assign above_count = above_reg;
    assign accepted    = acc_flag_reg;

    assign r2m1 = {r_reg, 1'b0} - N_W'(1);
    assign la   = mul_prod[X_W-1:0];
    assign p2x2 = {p2_reg, 1'b0};
    assign rhs  = {mul_prod[RT_W-1:0], 2'b00};

    // operand selection for the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_P2:
            begin
                mul_a = P_W'(n1_reg);
                mul_b = B_W'(n2_reg);
            end
            ST_LA:
            begin
                mul_a = P_W'(r2m1);
                mul_b = B_W'(n_reg);
            end
            ST_SQ:
            begin
                mul_a = P_W'(x_reg);
                mul_b = B_W'(x_reg);
            end
            ST_M:
            begin
                mul_a = P_W'(SCALE);
                mul_b = B_W'(n_reg - N_W'(1));
            end
            ST_LHS:
            begin
                mul_a = P_W'(lhs_reg);
                mul_b = B_W'(m_reg);
            end
            ST_T:
            begin
                mul_a = P_W'(p2_reg);
                mul_b = B_W'(p2_reg - P2_W'(n_reg));
            end
            ST_RHS:
            begin
                mul_a = P_W'(t_reg);
                mul_b = B_W'(zsq);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mul_start_next = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        pass_next      = pass_reg;
        r_next         = r_reg;
        n1_next        = n1_reg;
        n2_next        = n2_reg;
        n_next         = n_reg;
        p2_next        = p2_reg;
        x_next         = x_reg;
        m_next         = m_reg;
        lhs_next       = lhs_reg;
        t_next         = t_reg;
        runs_out_next  = runs_reg;
        below_out_next = below_reg;
        above_out_next = above_reg;
        acc_flag_next  = acc_flag_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    r_next  = runs_new;
                    n1_next = below_new;
                    n2_next = above_new;
                    n_next  = N_W'(below_new) + N_W'(above_new);
                    if ((runs_new == '0) || (below_new == '0) || (above_new == '0))
                    begin
                        pass_next  = 1'b0;
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        mul_start_next = 1'b1;
                        state_next     = ST_P2;
                    end
                end
            end
            ST_P2:
            begin
                if (mul_done)
                begin
                    p2_next        = {mul_prod[P2_W-2:0], 1'b0};
                    mul_start_next = 1'b1;
                    state_next     = ST_LA;
                end
            end
            ST_LA:
            begin
                if (mul_done)
                begin
                    x_next         = (la >= p2x2) ? (la - p2x2) : (p2x2 - la);
                    mul_start_next = 1'b1;
                    state_next     = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (mul_done)
                begin
                    lhs_next       = mul_prod[LHS_W-1:0];
                    mul_start_next = 1'b1;
                    state_next     = ST_M;
                end
            end
            ST_M:
            begin
                if (mul_done)
                begin
                    m_next         = mul_prod[M_W-1:0];
                    mul_start_next = 1'b1;
                    state_next     = ST_LHS;
                end
            end
            ST_LHS:
            begin
                if (mul_done)
                begin
                    lhs_next       = mul_prod[LHS_W-1:0];
                    mul_start_next = 1'b1;
                    state_next     = ST_T;
                end
            end
            ST_T:
            begin
                if (mul_done)
                begin
                    t_next         = mul_prod[T_W-1:0];
                    mul_start_next = 1'b1;
                    state_next     = ST_RHS;
                end
            end
            ST_RHS:
            begin
                if (mul_done)
                begin
                    pass_next  = CMP_W'(lhs_reg) <= CMP_W'(rhs);
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                // wait for the result word slot to free up
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    runs_out_next  = r_reg;
                    below_out_next = n1_reg;
                    above_out_next = n2_reg;
                    acc_flag_next  = pass_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mul_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mul_start_reg <= mul_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg     <= pass_next;
        r_reg        <= r_next;
        n1_reg       <= n1_next;
        n2_reg       <= n2_next;
        n_reg        <= n_next;
        p2_reg       <= p2_next;
        x_reg        <= x_next;
        m_reg        <= m_next;
        lhs_reg      <= lhs_next;
        t_reg        <= t_next;
        runs_reg     <= runs_out_next;
        below_reg    <= below_out_next;
        above_reg    <= above_out_next;
        acc_flag_reg <= acc_flag_next;
    end

endmodule
